>>> sv/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and beat types.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      logic                    kind;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] removed_value;
      status_type              status;
   } rsp_type;

   typedef struct packed {
      op_type                  op;
      logic signed [VAL_W-1:0] value;
   } ctl_type;

endpackage

>>> sv/spq_cell.sv
// One storage cell of the sorted chain: compares, shifts up on insert, down on remove.
module spq_cell import spq_pkg::*; (
   input  logic                    clock,
   input  ctl_type                 ctl,
   input  logic                    used,
   input  logic                    left_flag,
   input  logic signed [VAL_W-1:0] left_val,
   input  logic signed [VAL_W-1:0] right_val,
   output logic signed [VAL_W-1:0] val,
   output logic                    flag
);

   logic signed [VAL_W-1:0] val_ff;
   logic signed [VAL_W-1:0] val_in;

   // flag: new value belongs at or below this cell; free cells count as +inf
   assign flag = !used || (ctl.value <= val_ff);
   assign val  = val_ff;

   always_comb begin
      val_in = val_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (left_flag) begin
               val_in = left_val;
            end else if (flag) begin
               val_in = ctl.value;
            end
         end
         OP_REMOVE: val_in = right_val;
         OP_HOLD:   val_in = val_ff;
         default:   val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

>>> sv/sorted_priority_queue.sv
// Top level of the sorted min-priority queue built as a chain of compare-and-shift cells.
//
// Usage:
//   Drive req_data and raise start; a beat is taken at a clock edge where start
//   is high and busy is low. busy stays low, so one insert or remove can be
//   taken every cycle.
//   Insert (kind 0) places the value ahead of all stored values that are
//   greater or equal; every cell compares against the new value in parallel
//   and the larger ones shift up one cell. Remove (kind 1) returns the
//   smallest value from cell 0 and every cell takes its upper neighbor.
//   Each beat gives exactly one result: rsp_strobe is high for one cycle, the
//   cycle after the request edge (throughput 1 per cycle), with
//   rsp_data holding removed_value and status (ok, full, empty).
//   A full insert or an empty remove leaves the queue unchanged and returns
//   zero in removed_value.
//   The receiver cannot stall: a result is gone after its one cycle.
//   Reset empties the queue (count to zero) and clears the strobe; cell
//   contents are not cleared and are only read below the count.
module sorted_priority_queue import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_strobe_ff;
   logic             rsp_strobe_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   ctl_type          ctl;
   logic             accept;
   logic             is_full;
   logic             is_empty;

   logic signed [VAL_W-1:0] cell_val  [CAPACITY];
   logic                    cell_flag [CAPACITY];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   always_comb begin
      ctl.value     = req_data.value;
      ctl.op        = OP_HOLD;
      count_in      = count_ff;
      rsp_strobe_in = accept;
      rsp_in        = rsp_ff;
      if (accept) begin
         rsp_in.removed_value = '0;
         rsp_in.status        = STATUS_OK;
         if (req_data.kind == KIND_INSERT) begin
            if (is_full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ctl.op   = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               ctl.op               = OP_REMOVE;
               rsp_in.removed_value = cell_val[0];
               count_in             = count_ff - CNT_W'(1);
            end
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_flag;
      logic signed [VAL_W-1:0] left_val;
      logic signed [VAL_W-1:0] right_val;

      if (i == 0) begin : g_first
         assign left_flag = 1'b0;
         assign left_val  = cell_val[i];
      end else begin : g_mid
         assign left_flag = cell_flag[i-1];
         assign left_val  = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_val = cell_val[i];
      end else begin : g_inner
         assign right_val = cell_val[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .used      (count_ff > CNT_W'(i)),
         .left_flag (left_flag),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .flag      (cell_flag[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("queue count beyond capacity");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted beat gave no result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STATUS_OK |-> rsp_data.removed_value == '0)
      else $error("failed beat returned a value");

   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STATUS_OK |-> $stable(count_ff))
      else $error("failed beat changed the count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_INSERT && is_full |=> rsp_data.status == STATUS_FULL)
      else $error("insert at capacity not reported full");

endmodule

>>> dv/sorted_priority_queue_check.sv
// Checker for the sorted priority queue: predicts each result beat and compares it.
module sorted_priority_queue_check import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      full_count,
   output int      empty_count
);

   logic signed [VAL_W-1:0] sorted_vals[$];
   rsp_type                 expected_rsps[$];
   int                      fails   = 0;
   int                      fulls   = 0;
   int                      empties = 0;

   function automatic rsp_type queue_outcome(req_type beat);
      rsp_type outcome;
      int      pos;
      outcome.removed_value = '0;
      outcome.status        = STATUS_OK;
      if (beat.kind == KIND_INSERT) begin
         if (sorted_vals.size() >= CAPACITY) begin
            outcome.status = STATUS_FULL;
         end else begin
            pos = sorted_vals.size();
            for (int k = 0; k < sorted_vals.size(); k++) begin
               if (beat.value <= sorted_vals[k]) begin
                  pos = k;
                  break;
               end
            end
            sorted_vals.insert(pos, beat.value);
         end
      end else if (sorted_vals.size() == 0) begin
         outcome.status = STATUS_EMPTY;
      end else begin
         outcome.removed_value = sorted_vals.pop_front();
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with no request outstanding");
               fails++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         want.removed_value, rsp_data.removed_value);
                  fails++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fails++;
               end
            end
         end
         if (start && !busy) begin
            want = queue_outcome(req_data);
            if (want.status == STATUS_FULL) fulls++;
            if (want.status == STATUS_EMPTY) empties++;
            expected_rsps.push_back(want);
         end
      end
      fail_count  <= fails;
      pending     <= expected_rsps.size();
      full_count  <= fulls;
      empty_count <= empties;
   end

endmodule

>>> dv/sorted_priority_queue_test.sv
// Testbench top for the sorted priority queue: clock, reset, request stimulus and verdict.
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int STALL_LIMIT      = 5000;
   localparam int BEATS_PER_PHASE  = 400;
   localparam int DRAIN_CYCLES     = 4;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int full_count;
   int empty_count;
   int idle_pct     = 0;
   int stall_cycles = 0;
   int beats_sent   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   sorted_priority_queue_check i_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .full_count  (full_count),
      .empty_count (empty_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_beat(input logic kind, input logic signed [VAL_W-1:0] value);
      req_type beat;
      beat.kind  = kind;
      beat.value = value;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      beats_sent++;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6:    v = $urandom_range(8) - 4;
         7:          v = {1'b1, {(VAL_W-1){1'b0}}};
         8:          v = {1'b0, {(VAL_W-1){1'b1}}};
         default:    v = {1'($urandom_range(1)), {(VAL_W-1){$urandom_range(1) == 1}}};
      endcase
      return v;
   endfunction

   // bursts with a biased insert share walk the fill level between empty and full
   task automatic run_random(input int count);
      int   left;
      int   burst;
      int   insert_pct;
      logic kind;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         case ($urandom_range(2))
            0:       insert_pct = 80;
            1:       insert_pct = 50;
            default: insert_pct = 20;
         endcase
         while (burst > 0 && left > 0) begin
            kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            send_beat(kind, pick_value());
            burst--;
            left--;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty remove, extremes, equal values, fill to full, full insert
      idle_pct = 30;
      send_beat(KIND_REMOVE, 32'sd0);
      send_beat(KIND_INSERT, 32'sd0);
      send_beat(KIND_INSERT, 32'sh7FFFFFFF);
      send_beat(KIND_INSERT, 32'sh80000000);
      send_beat(KIND_INSERT, -32'sd1);
      send_beat(KIND_INSERT, 32'sd0);
      send_beat(KIND_INSERT, 32'sd1);
      send_beat(KIND_INSERT, -32'sd1);
      send_beat(KIND_INSERT, 32'sh7FFFFFFF);
      send_beat(KIND_INSERT, 32'sh80000000);
      send_beat(KIND_INSERT, 32'sh55555555);
      send_beat(KIND_INSERT, 32'shAAAAAAAA);
      send_beat(KIND_INSERT, 32'sd7);
      send_beat(KIND_INSERT, -32'sd7);
      send_beat(KIND_INSERT, 32'sd7);
      send_beat(KIND_INSERT, 32'sh00010000);
      send_beat(KIND_INSERT, 32'shFFFF0000);
      send_beat(KIND_INSERT, 32'sd42);
      send_beat(KIND_REMOVE, 32'shFFFFFFFF);
      send_beat(KIND_REMOVE, 32'sd0);
      send_beat(KIND_INSERT, 32'sh80000000);

      run_random(BEATS_PER_PHASE);
      idle_pct = 72;
      run_random(BEATS_PER_PHASE);
      idle_pct = 0;
      run_random(BEATS_PER_PHASE);

      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d request beats over three pacing phases (30%%, 72%%, no idle).",
               beats_sent);
      $display("Full inserts seen: %0d, empty removes seen: %0d.", full_count, empty_count);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
